>>> sv/arc_pkg.sv
// Shared types, constants and codes of the ARP resolver cache.
`timescale 1ns / 1ps

package arc_pkg;

  localparam int MAP_ENTRIES   = 16;
  localparam int REQ_ENTRIES   = 16;
  localparam int PENDING_DEPTH = 16;

  localparam int MAP_AW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int REQ_AW  = (REQ_ENTRIES > 1) ? $clog2(REQ_ENTRIES) : 1;
  localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);
  localparam int SCAN_N  = (MAP_ENTRIES > REQ_ENTRIES) ? MAP_ENTRIES : REQ_ENTRIES;
  localparam int SCAN_CW = $clog2(SCAN_N + 1);

  localparam int MAC_W  = 48;
  localparam int IP_W   = 32;
  localparam int TAG_W  = 16;
  localparam int TIME_W = 48;
  localparam int MS_W   = 32;
  localparam int ELA_W  = 16;

  localparam logic [MAC_W-1:0] MAC_BCAST      = '1;
  localparam logic [MS_W-1:0]  LIFETIME_RESET = 32'd30000;
  localparam logic [MS_W-1:0]  HOLDOFF_RESET  = 32'd5000;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF  = 2'd3;

  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_RECV = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] FTYPE_IPV4 = 2'd0;
  localparam logic [1:0] FTYPE_ARP  = 2'd1;

  typedef enum logic [2:0] {
    KIND_IPV4      = 3'd0,
    KIND_ARP_REQ   = 3'd1,
    KIND_ARP_REPLY = 3'd2,
    KIND_DELIVER   = 3'd3,
    KIND_DROP      = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_SEND_ARP,
    ST_SEND_QUEUE,
    ST_DELIVER,
    ST_LEARN,
    ST_REPLY,
    ST_PEND_RD,
    ST_PEND_EV,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [IP_W-1:0]  next_hop_ip;
    logic [TAG_W-1:0] datagram_tag;
    logic [MAC_W-1:0] frame_dst_mac;
    logic [1:0]       frame_type;
    logic             payload_ok;
    logic             arp_is_request;
    logic [IP_W-1:0]  arp_sender_ip;
    logic [MAC_W-1:0] arp_sender_mac;
    logic [IP_W-1:0]  arp_target_ip;
    logic [ELA_W-1:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    kind_e            out_kind;
    logic [MAC_W-1:0] dst_mac;
    logic [IP_W-1:0]  arp_target_ip_out;
    logic [MAC_W-1:0] arp_target_mac_out;
    logic [TAG_W-1:0] tag_out;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [MAC_W-1:0] own_mac;
    logic [IP_W-1:0]  own_ip;
    logic [MS_W-1:0]  mapping_lifetime_ms;
    logic [MS_W-1:0]  request_holdoff_ms;
  } cfg_t;

  typedef struct packed {
    logic               idle;
    logic [PEND_CW-1:0] pend_cnt;
  } stat_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] expiry;
  } map_entry_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [TIME_W-1:0] sent;
  } req_entry_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [IP_W-1:0]  ip;
  } pend_entry_t;

endpackage

>>> sv/arc_if.sv
// Channel interfaces of the ARP resolver cache: input items, results, configuration.
`timescale 1ns / 1ps

interface arc_item_if import arc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [IP_W-1:0]  next_hop_ip;
  logic [TAG_W-1:0] datagram_tag;
  logic [MAC_W-1:0] frame_dst_mac;
  logic [1:0]       frame_type;
  logic             payload_ok;
  logic             arp_is_request;
  logic [IP_W-1:0]  arp_sender_ip;
  logic [MAC_W-1:0] arp_sender_mac;
  logic [IP_W-1:0]  arp_target_ip;
  logic [ELA_W-1:0] elapsed_ms;

  modport source (output valid, func, next_hop_ip, datagram_tag, frame_dst_mac, frame_type,
                  payload_ok, arp_is_request, arp_sender_ip, arp_sender_mac, arp_target_ip,
                  elapsed_ms, input ready);
  modport sink (input valid, func, next_hop_ip, datagram_tag, frame_dst_mac, frame_type,
                payload_ok, arp_is_request, arp_sender_ip, arp_sender_mac, arp_target_ip,
                elapsed_ms, output ready);
endinterface

interface arc_res_if import arc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       out_kind;
  logic [MAC_W-1:0] dst_mac;
  logic [IP_W-1:0]  arp_target_ip_out;
  logic [MAC_W-1:0] arp_target_mac_out;
  logic [TAG_W-1:0] tag_out;
  logic             last;

  modport source (output valid, out_kind, dst_mac, arp_target_ip_out, arp_target_mac_out,
                  tag_out, last, input ready);
  modport sink (input valid, out_kind, dst_mac, arp_target_ip_out, arp_target_mac_out,
                tag_out, last, output ready);
endinterface

interface arc_cfg_if import arc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MAC_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/arc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module arc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic [AW-1:0]          raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> sv/arc_engine.sv
// Sequencer of the resolver: table scans, learning, request holdoff and pending queue.
`timescale 1ns / 1ps

module arc_engine import arc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  arc_item_if.sink    item_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o,
  output stat_t       stat_o
);
  localparam int MAP_DW  = $bits(map_entry_t);
  localparam int REQ_DW  = $bits(req_entry_t);
  localparam int PEND_DW = $bits(pend_entry_t);

  state_e state_q, state_d;
  item_t  item_q;
  logic   hold_v_q;
  res_t   hold_q;
  logic [TIME_W-1:0] now_q;
  logic [MAP_ENTRIES-1:0] map_valid_q;
  logic [REQ_ENTRIES-1:0] req_valid_q;
  logic [PEND_CW-1:0] pend_cnt_q, pi_q, keep_q;
  logic [SCAN_CW-1:0] cnt_q, eidx_q;
  logic ev_q;

  logic mhit_q, mmatch_q, mfree_q;
  logic [MAC_W-1:0]  mmac_q;
  logic [MAP_AW-1:0] mmatch_idx_q, mfree_idx_q, mmin_idx_q;
  logic [TIME_W-1:0] mmin_exp_q;
  logic rhit_q, rfree_q;
  logic [REQ_AW-1:0] rfree_idx_q, rmin_idx_q;
  logic [TIME_W-1:0] rmin_time_q;

  // Memory ports.
  logic map_we, req_we, pend_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [REQ_AW-1:0]  req_waddr;
  logic [PEND_AW-1:0] pend_waddr;
  map_entry_t  map_wr, map_rd;
  req_entry_t  req_wr, req_rd;
  pend_entry_t pend_wr, pend_rd;
  logic [MAP_DW-1:0]  map_rdata;
  logic [REQ_DW-1:0]  req_rdata;
  logic [PEND_DW-1:0] pend_rdata;

  // Control.
  logic emit_req, emit_ok, emit_fire;
  res_t emit_res;
  logic [IP_W-1:0] key_ip;
  logic scan_done, dst_ok;
  logic map_ev, req_ev, mv, rv;
  logic [MAP_AW-1:0] midx;
  logic [REQ_AW-1:0] ridx;
  logic m_match, m_live, m_free, r_match, r_old;
  logic [TIME_W-1:0] r_age;
  logic [TIME_W:0] exp_sum, tick_sum;
  logic [TIME_W-1:0] exp_new;

  arc_ram #(.WIDTH(MAP_DW), .DEPTH(MAP_ENTRIES)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wr),
    .raddr_i (cnt_q[MAP_AW-1:0]),
    .rdata_o (map_rdata)
  );

  arc_ram #(.WIDTH(REQ_DW), .DEPTH(REQ_ENTRIES)) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (req_we),
    .waddr_i (req_waddr),
    .wdata_i (req_wr),
    .raddr_i (cnt_q[REQ_AW-1:0]),
    .rdata_o (req_rdata)
  );

  arc_ram #(.WIDTH(PEND_DW), .DEPTH(PENDING_DEPTH)) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wr),
    .raddr_i (pi_q[PEND_AW-1:0]),
    .rdata_o (pend_rdata)
  );

  assign map_rd  = map_entry_t'(map_rdata);
  assign req_rd  = req_entry_t'(req_rdata);
  assign pend_rd = pend_entry_t'(pend_rdata);

  assign item_i.ready = (state_q == ST_IDLE);
  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.pend_cnt = pend_cnt_q;

  assign key_ip = (item_q.func == FUNC_SEND) ? item_q.next_hop_ip : item_q.arp_sender_ip;
  assign dst_ok = (item_q.frame_dst_mac == cfg_i.own_mac) ||
                  (item_q.frame_dst_mac == MAC_BCAST);
  assign scan_done = ev_q && (eidx_q == SCAN_CW'(SCAN_N - 1));

  // Scan evaluation: the data read for entry eidx_q arrives in the cycle after its address.
  assign map_ev  = (state_q == ST_SCAN) && ev_q && (eidx_q < SCAN_CW'(MAP_ENTRIES));
  assign req_ev  = (state_q == ST_SCAN) && ev_q && (eidx_q < SCAN_CW'(REQ_ENTRIES));
  assign midx    = eidx_q[MAP_AW-1:0];
  assign ridx    = eidx_q[REQ_AW-1:0];
  assign mv      = map_valid_q[midx];
  assign rv      = req_valid_q[ridx];
  assign m_match = mv && (map_rd.ip == key_ip);
  assign m_live  = m_match && (now_q <= map_rd.expiry);
  assign m_free  = !mv || (now_q > map_rd.expiry);
  assign r_match = rv && (req_rd.ip == key_ip);
  assign r_age   = (now_q >= req_rd.sent) ? (now_q - req_rd.sent) : '0;
  assign r_old   = rv && (r_age >= {{(TIME_W-MS_W){1'b0}}, cfg_i.request_holdoff_ms});

  assign exp_sum  = {1'b0, now_q} + {{(TIME_W-MS_W+1){1'b0}}, cfg_i.mapping_lifetime_ms};
  assign exp_new  = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
  assign tick_sum = {1'b0, now_q} + {{(TIME_W-ELA_W+1){1'b0}}, item_q.elapsed_ms};

  assign emit_ok   = !hold_v_q || res_ready_i;
  assign emit_fire = emit_req && emit_ok;

  // The held result goes out once the next one exists, or at the end marked last.
  assign res_valid_o = hold_v_q && (emit_req || (state_q == ST_FLUSH));
  always_comb begin
    res_o = hold_q;
    res_o.last = (state_q == ST_FLUSH);
  end

  // Outputs of the sequencer.
  always_comb begin
    emit_req = 1'b0;
    emit_res = '{out_kind: KIND_IPV4, default: '0};
    map_we = 1'b0;
    map_waddr = mmin_idx_q;
    map_wr = '{ip: item_q.arp_sender_ip, mac: item_q.arp_sender_mac, expiry: exp_new};
    req_we = 1'b0;
    req_waddr = rfree_q ? rfree_idx_q : rmin_idx_q;
    req_wr = '{ip: item_q.next_hop_ip, sent: now_q};
    pend_we = 1'b0;
    pend_waddr = pend_cnt_q[PEND_AW-1:0];
    pend_wr = '{tag: item_q.datagram_tag, ip: item_q.next_hop_ip};
    case (state_q)
      ST_SEND_ARP: begin
        if (mhit_q) begin
          emit_req = 1'b1;
          emit_res.out_kind = KIND_IPV4;
          emit_res.dst_mac = mmac_q;
          emit_res.tag_out = item_q.datagram_tag;
        end else if (!rhit_q) begin
          emit_req = 1'b1;
          emit_res.out_kind = KIND_ARP_REQ;
          emit_res.dst_mac = MAC_BCAST;
          emit_res.arp_target_ip_out = item_q.next_hop_ip;
          req_we = emit_ok;
        end
      end
      ST_SEND_QUEUE: begin
        if (pend_cnt_q < PEND_CW'(PENDING_DEPTH)) begin
          pend_we = 1'b1;
        end else begin
          emit_req = 1'b1;
          emit_res.out_kind = KIND_DROP;
          emit_res.tag_out = item_q.datagram_tag;
        end
      end
      ST_DELIVER: begin
        emit_req = 1'b1;
        emit_res.out_kind = KIND_DELIVER;
        emit_res.tag_out = item_q.datagram_tag;
      end
      ST_LEARN: begin
        map_we = 1'b1;
        if (mmatch_q) begin
          map_waddr = mmatch_idx_q;
        end else if (mfree_q) begin
          map_waddr = mfree_idx_q;
        end
      end
      ST_REPLY: begin
        if (item_q.arp_is_request && (item_q.arp_target_ip == cfg_i.own_ip)) begin
          emit_req = 1'b1;
          emit_res.out_kind = KIND_ARP_REPLY;
          emit_res.dst_mac = item_q.arp_sender_mac;
          emit_res.arp_target_ip_out = item_q.arp_sender_ip;
          emit_res.arp_target_mac_out = item_q.arp_sender_mac;
        end
      end
      ST_PEND_EV: begin
        // Only the address just learned can have become live since the last release.
        if (pend_rd.ip == item_q.arp_sender_ip) begin
          emit_req = 1'b1;
          emit_res.out_kind = KIND_IPV4;
          emit_res.dst_mac = item_q.arp_sender_mac;
          emit_res.tag_out = pend_rd.tag;
        end else begin
          pend_we = 1'b1;
          pend_waddr = keep_q[PEND_AW-1:0];
          pend_wr = pend_rd;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (item_q.func)
          FUNC_SEND: state_d = ST_SCAN;
          FUNC_TICK: state_d = ST_SCAN;
          FUNC_RECV: begin
            if (dst_ok && item_q.payload_ok && (item_q.frame_type == FTYPE_IPV4)) begin
              state_d = ST_DELIVER;
            end else if (dst_ok && item_q.payload_ok && (item_q.frame_type == FTYPE_ARP)) begin
              state_d = ST_SCAN;
            end else begin
              state_d = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (scan_done) begin
          case (item_q.func)
            FUNC_SEND: state_d = ST_SEND_ARP;
            FUNC_RECV: state_d = ST_LEARN;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_SEND_ARP: begin
        if (!emit_req) begin
          state_d = ST_SEND_QUEUE;
        end else if (emit_ok) begin
          state_d = mhit_q ? ST_FLUSH : ST_SEND_QUEUE;
        end
      end
      ST_SEND_QUEUE: begin
        if (!emit_req || emit_ok) begin
          state_d = ST_FLUSH;
        end
      end
      ST_DELIVER: begin
        if (emit_ok) begin
          state_d = ST_FLUSH;
        end
      end
      ST_LEARN: state_d = ST_REPLY;
      ST_REPLY: begin
        if (!emit_req || emit_ok) begin
          state_d = ST_PEND_RD;
        end
      end
      ST_PEND_RD: state_d = (pi_q < pend_cnt_q) ? ST_PEND_EV : ST_FLUSH;
      ST_PEND_EV: begin
        if (!emit_req || emit_ok) begin
          state_d = ST_PEND_RD;
        end
      end
      ST_FLUSH: begin
        if (!hold_v_q || res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hold_v_q <= 1'b0;
      now_q <= '0;
      map_valid_q <= '0;
      req_valid_q <= '0;
      pend_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (emit_fire) begin
        hold_v_q <= 1'b1;
      end else if ((state_q == ST_FLUSH) && res_ready_i) begin
        hold_v_q <= 1'b0;
      end
      if ((state_q == ST_DISPATCH) && (item_q.func == FUNC_TICK)) begin
        now_q <= tick_sum[TIME_W] ? '1 : tick_sum[TIME_W-1:0];
      end
      if (map_we) begin
        map_valid_q[map_waddr] <= 1'b1;
      end
      if (req_ev && ((item_q.func == FUNC_RECV && r_match) ||
                     (item_q.func == FUNC_TICK && r_old))) begin
        req_valid_q[ridx] <= 1'b0;
      end
      if (req_we) begin
        req_valid_q[req_waddr] <= 1'b1;
      end
      if ((state_q == ST_SEND_QUEUE) && pend_we) begin
        pend_cnt_q <= pend_cnt_q + 1'b1;
      end else if ((state_q == ST_PEND_RD) && !(pi_q < pend_cnt_q)) begin
        pend_cnt_q <= keep_q;
      end
    end
  end

  // Item, scan and search registers.
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q <= '{func: item_i.func, next_hop_ip: item_i.next_hop_ip,
                  datagram_tag: item_i.datagram_tag, frame_dst_mac: item_i.frame_dst_mac,
                  frame_type: item_i.frame_type, payload_ok: item_i.payload_ok,
                  arp_is_request: item_i.arp_is_request, arp_sender_ip: item_i.arp_sender_ip,
                  arp_sender_mac: item_i.arp_sender_mac, arp_target_ip: item_i.arp_target_ip,
                  elapsed_ms: item_i.elapsed_ms};
    end
    if (emit_fire) begin
      hold_q <= emit_res;
    end
    if (state_q == ST_DISPATCH) begin
      cnt_q <= '0;
      ev_q <= 1'b0;
      eidx_q <= '0;
      mhit_q <= 1'b0;
      mmatch_q <= 1'b0;
      mfree_q <= 1'b0;
      mmin_exp_q <= '1;
      mmin_idx_q <= '0;
      rhit_q <= 1'b0;
      rfree_q <= 1'b0;
      rmin_time_q <= '1;
      rmin_idx_q <= '0;
    end else if (state_q == ST_SCAN) begin
      ev_q <= (cnt_q < SCAN_CW'(SCAN_N));
      eidx_q <= cnt_q;
      if (cnt_q < SCAN_CW'(SCAN_N)) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
    if (map_ev) begin
      if (m_live && !mhit_q) begin
        mhit_q <= 1'b1;
        mmac_q <= map_rd.mac;
      end
      if (m_match && !mmatch_q) begin
        mmatch_q <= 1'b1;
        mmatch_idx_q <= midx;
      end
      if (m_free && !mfree_q) begin
        mfree_q <= 1'b1;
        mfree_idx_q <= midx;
      end
      if (map_rd.expiry < mmin_exp_q) begin
        mmin_exp_q <= map_rd.expiry;
        mmin_idx_q <= midx;
      end
    end
    if (req_ev) begin
      if (r_match) begin
        rhit_q <= 1'b1;
      end
      if (!rv && !rfree_q) begin
        rfree_q <= 1'b1;
        rfree_idx_q <= ridx;
      end
      if (req_rd.sent < rmin_time_q) begin
        rmin_time_q <= req_rd.sent;
        rmin_idx_q <= ridx;
      end
    end
    if (state_q == ST_LEARN) begin
      pi_q <= '0;
      keep_q <= '0;
    end else if ((state_q == ST_PEND_EV) && (!emit_req || emit_ok)) begin
      pi_q <= pi_q + 1'b1;
      if (!emit_req) begin
        keep_q <= keep_q + 1'b1;
      end
    end
  end
endmodule

>>> sv/arp_resolver_cache.sv
// Top level: a send or tick item makes one pass over both tables, an ARP message makes
// that pass and then one over the pending queue, and an IPv4 delivery needs no scan.
// One item is worked on at a time; results leave one at a time through an output register,
// and a result can wait there while the next item is taken.
// Reset clears the valid bits, the pending count and the clock and loads the
// register defaults; the table memories are not cleared.
`timescale 1ns / 1ps

module arp_resolver_cache import arc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  arc_cfg_if.sink   cfg_i,
  arc_item_if.sink  item_i,
  arc_res_if.source result_o
);
  cfg_t  cfg_q;
  logic  out_v_q;
  res_t  out_q;
  logic  res_valid, res_ready;
  res_t  res;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{own_mac: '0, own_ip: '0, mapping_lifetime_ms: LIFETIME_RESET,
                 request_holdoff_ms: HOLDOFF_RESET};
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_OWN_MAC:  cfg_q.own_mac <= cfg_i.data;
        CFG_OWN_IP:   cfg_q.own_ip <= cfg_i.data[IP_W-1:0];
        CFG_LIFETIME: cfg_q.mapping_lifetime_ms <= cfg_i.data[MS_W-1:0];
        CFG_HOLDOFF:  cfg_q.request_holdoff_ms <= cfg_i.data[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  arc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .stat_o      (stat)
  );

  // Output register: a new result enters when the slot is empty or being drained.
  assign res_ready = !out_v_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_ready) begin
      out_v_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign result_o.valid              = out_v_q;
  assign result_o.out_kind           = out_q.out_kind;
  assign result_o.dst_mac            = out_q.dst_mac;
  assign result_o.arp_target_ip_out  = out_q.arp_target_ip_out;
  assign result_o.arp_target_mac_out = out_q.arp_target_mac_out;
  assign result_o.tag_out            = out_q.tag_out;
  assign result_o.last               = out_q.last;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !stat.idle)
    else $error("engine stayed idle after a transfer on the item channel");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.pend_cnt <= PEND_CW'(PENDING_DEPTH))
    else $error("pending count beyond queue depth");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(stat.idle) |-> $stable(stat.pend_cnt))
    else $error("pending count changed while idle");

  a_res_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> out_v_q)
    else $error("result lost at output register");
`endif
endmodule
